@@ hdl/at_rw_pkg.sv @@
// ----------------------------------------------------------------------------
// at_rw_pkg
// Shared types and constants for the AT response waiter: opcodes, request
// states, status codes and the terminator patterns.
// ----------------------------------------------------------------------------
package at_rw_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TICK    = 2'd2,
    OP_COLLECT = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SENT    = 4'b0010,
    ST_STARTED = 4'b0100,
    ST_TIMEOUT = 4'b1000
  } state_t;

  localparam logic [1:0] STATUS_IDLE    = 2'd0;
  localparam logic [1:0] STATUS_SENT    = 2'd1;
  localparam logic [1:0] STATUS_STARTED = 2'd2;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

  localparam int ELAPSED_W = 17;
  localparam int TIMEOUT_W = 16;

  localparam logic [7:0] CHAR_CR = 8'h0d;

  // terminators, first character in the top byte
  localparam int OK_LEN  = 6;
  localparam int ERR_LEN = 9;
  localparam logic [8*OK_LEN-1:0]  OK_PATTERN  = {8'h0d, 8'h0a, "OK", 8'h0d, 8'h0a};
  localparam logic [8*ERR_LEN-1:0] ERR_PATTERN = {8'h0d, 8'h0a, "ERROR", 8'h0d, 8'h0a};

  // matcher control for one beat
  typedef struct packed {
    logic clr;
    logic step;
  } match_ctl_t;

  function automatic logic [1:0] status_code(state_t st);
    logic [1:0] code;
    case (st)
      ST_IDLE:    code = STATUS_IDLE;
      ST_SENT:    code = STATUS_SENT;
      ST_STARTED: code = STATUS_STARTED;
      ST_TIMEOUT: code = STATUS_TIMEOUT;
      default:    code = STATUS_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/at_rw_matcher.sv @@
// ----------------------------------------------------------------------------
// at_rw_matcher
// Streaming matcher for one terminator string. Holds the match position;
// on a step a mismatch falls back to one after CR, else to zero.
// ----------------------------------------------------------------------------
module at_rw_matcher #(
  parameter int                  LEN     = at_rw_pkg::OK_LEN,
  parameter logic [8*LEN-1:0]    PATTERN = at_rw_pkg::OK_PATTERN
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  at_rw_pkg::match_ctl_t  ctl,
  input  logic [7:0]             data_byte,
  output logic                   hit
);
  import at_rw_pkg::*;

  localparam int POS_W = (LEN > 1) ? $clog2(LEN) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LEN - 1);

  logic [7:0]       pat_chars [LEN];
  logic [POS_W-1:0] pos_r, pos_nxt, pos_use;
  logic             char_eq;

  for (genvar i = 0; i < LEN; i++) begin : g_chars
    assign pat_chars[i] = PATTERN[8*(LEN-1-i) +: 8];
  end

  // positions beyond the pattern restart at zero
  assign pos_use = (pos_r > POS_LAST) ? '0 : pos_r;
  assign char_eq = (data_byte == pat_chars[pos_use]);
  assign hit     = char_eq && (pos_use == POS_LAST);

  always_comb begin
    pos_nxt = pos_r;
    if (ctl.clr) begin
      pos_nxt = '0;
    end else if (ctl.step) begin
      if (char_eq) begin
        pos_nxt = (pos_use == POS_LAST) ? '0 : pos_use + POS_W'(1);
      end else begin
        pos_nxt = (data_byte == CHAR_CR) ? POS_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ hdl/at_rw_core.sv @@
// ----------------------------------------------------------------------------
// at_rw_core
// Request tracker: status state machine, elapsed-time counter, timeout
// limit, both terminator matchers and the result register.
// ----------------------------------------------------------------------------
module at_rw_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        modem_on,
  input  logic        item_valid,
  input  logic [1:0]  item_opcode,
  input  logic [7:0]  item_byte,
  input  logic [15:0] item_timeout,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_accepted,
  output logic        out_byte_kept,
  output logic [7:0]  out_kept_byte,
  output logic        out_found_ok,
  output logic        out_found_error,
  output logic        out_finished
);
  import at_rw_pkg::*;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  state_t                st_r, st_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [TIMEOUT_W-1:0]  limit_r, limit_nxt;
  logic                  fire;
  logic                  take;
  logic                  accepted, finished;
  logic                  ok_hit, err_hit;
  logic                  over_cur, over_nxt;
  match_ctl_t            mctl;
  op_t                   op;

  logic                  out_valid_r;
  logic [1:0]            status_r;
  logic                  accepted_r, kept_r, fok_r, ferr_r, fin_r;
  logic [7:0]            kbyte_r;

  assign op      = op_t'(item_opcode);
  assign advance = !out_valid_r || out_ready;
  assign fire    = item_valid && advance;

  at_rw_matcher #(.LEN(OK_LEN), .PATTERN(OK_PATTERN)) u_ok (
    .clk(clk), .rst_n(rst_n), .ctl(mctl), .data_byte(item_byte), .hit(ok_hit)
  );

  at_rw_matcher #(.LEN(ERR_LEN), .PATTERN(ERR_PATTERN)) u_err (
    .clk(clk), .rst_n(rst_n), .ctl(mctl), .data_byte(item_byte), .hit(err_hit)
  );

  assign over_cur = elapsed_r > {1'b0, limit_r};
  assign over_nxt = elapsed_nxt > {1'b0, limit_r};

  always_comb begin
    st_nxt      = st_r;
    elapsed_nxt = elapsed_r;
    limit_nxt   = limit_r;
    take        = 1'b0;
    accepted    = 1'b0;
    finished    = 1'b0;
    mctl        = '0;
    if (fire) begin
      case (op)
        OP_START: begin
          if (modem_on && st_r == ST_IDLE) begin
            limit_nxt   = item_timeout;
            elapsed_nxt = '0;
            mctl.clr    = 1'b1;
            st_nxt      = ST_SENT;
            accepted    = 1'b1;
          end
        end
        OP_BYTE: begin
          // no timeout check on the first byte of a response
          if (st_r == ST_SENT) begin
            take = 1'b1;
          end else if (st_r == ST_STARTED) begin
            if (over_cur) begin
              st_nxt = ST_TIMEOUT;
            end else begin
              take = 1'b1;
            end
          end
          if (take) begin
            mctl.step = 1'b1;
            st_nxt    = (ok_hit || err_hit) ? ST_IDLE : ST_STARTED;
          end
        end
        OP_TICK: begin
          if (elapsed_r != ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + ELAPSED_W'(1);
          end
          if ((st_r == ST_SENT || st_r == ST_STARTED) && over_nxt) begin
            st_nxt = ST_TIMEOUT;
          end
        end
        OP_COLLECT: begin
          if (st_r == ST_IDLE || st_r == ST_TIMEOUT) begin
            finished = 1'b1;
            st_nxt   = ST_IDLE;
          end
        end
        default: begin
          st_nxt = st_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      elapsed_r   <= '0;
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      elapsed_r <= elapsed_nxt;
      limit_r   <= limit_nxt;
      if (advance) begin
        out_valid_r <= item_valid;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r   <= status_code(st_nxt);
      accepted_r <= accepted;
      kept_r     <= take;
      kbyte_r    <= take ? item_byte : 8'h00;
      fok_r      <= take && ok_hit;
      ferr_r     <= take && err_hit;
      fin_r      <= finished;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_accepted    = accepted_r;
  assign out_byte_kept   = kept_r;
  assign out_kept_byte   = kbyte_r;
  assign out_found_ok    = fok_r;
  assign out_found_error = ferr_r;
  assign out_finished    = fin_r;

  a_accept_sent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && accepted_r |-> status_r == STATUS_SENT)
    else $error("accepted start without sent status");

  a_found_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (fok_r || ferr_r) |-> kept_r && status_r == STATUS_IDLE)
    else $error("terminator found but request not closed");

  a_finished_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fin_r |-> status_r == STATUS_IDLE && !kept_r && !accepted_r)
    else $error("finished result with wrong status");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && accepted |=> elapsed_r == '0 && st_r == ST_SENT)
    else $error("accepted start did not clear elapsed time");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(st_r) && $stable(elapsed_r))
    else $error("state moved while result stalled");

endmodule

@@ hdl/at_response_waiter.sv @@
// ----------------------------------------------------------------------------
// at_response_waiter
// Tracks one outstanding modem AT request and detects the end of its reply.
//
// Input channel (in_valid/in_ready) carries one beat per event: start
// request with a timeout, received byte, millisecond tick or collect.
// Result channel (out_valid/out_ready) returns exactly one beat per input
// beat, in order, with the status after the event and per-event flags.
// cfg_wr_en/cfg_wr_data write modem_on; change it only while idle.
//
// An accepted beat goes through the input register, then the status/matcher
// update into the result register. Throughput is one beat per cycle while
// the receiver takes results; the state update is a single pass of small
// logic per beat, so back-to-back beats flow without bubbles. When the
// receiver stalls, the result register holds; the input register takes one
// more beat only if it is empty, after which in_ready drops.
// Synchronous reset (rst_n low) returns to idle with all counters and
// matchers cleared and modem_on low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module at_response_waiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_timeout_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_accepted,
  output logic        out_byte_kept,
  output logic [7:0]  out_kept_byte,
  output logic        out_found_ok,
  output logic        out_found_error,
  output logic        out_finished
);
  import at_rw_pkg::*;

  logic                 modem_on_r;
  logic                 in_valid_r;
  logic [1:0]           opcode_r;
  logic [7:0]           byte_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 advance;

  // input stage frees up whenever the core consumes its beat
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modem_on_r <= 1'b0;
      in_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        modem_on_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opcode_r  <= in_opcode;
      byte_r    <= in_data_byte;
      timeout_r <= in_timeout_ms;
    end
  end

  at_rw_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .modem_on        (modem_on_r),
    .item_valid      (in_valid_r),
    .item_opcode     (opcode_r),
    .item_byte       (byte_r),
    .item_timeout    (timeout_r),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_accepted    (out_accepted),
    .out_byte_kept   (out_byte_kept),
    .out_kept_byte   (out_kept_byte),
    .out_found_ok    (out_found_ok),
    .out_found_error (out_found_error),
    .out_finished    (out_finished)
  );

endmodule

@@ tb/tb_at_response_waiter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_at_response_waiter
// Drives start, byte, tick and collect beats into the AT response waiter and
// checks every result beat against a cycle-free model of the request tracker.
// A short table covers reset behavior, field extremes and both terminators.
// Random request sequences follow, under four idling mixes and both modem
// power settings.
// ----------------------------------------------------------------------------
module tb_at_response_waiter;
  import at_rw_pkg::*;

  localparam int PHASE_ITEMS  = 115;
  localparam int OFF_ITEMS    = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int LAT_PAD      = 4;
  localparam int MAX_PRINTS   = 40;
  localparam logic [16:0] MS_MAX = 17'h1ffff;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [15:0] tmo;
  } beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic       accepted;
    logic       byte_kept;
    logic [7:0] kept_byte;
    logic       found_ok;
    logic       found_error;
    logic       finished;
  } reply_t;

  typedef struct {
    bit     is_cfg;
    bit     cfg_val;
    beat_t  beat;
    bit     known;
    reply_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [7:0]  in_data_byte = '0;
  logic [15:0] in_timeout_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_accepted;
  logic        out_byte_kept;
  logic [7:0]  out_kept_byte;
  logic        out_found_ok;
  logic        out_found_error;
  logic        out_finished;

  // tracker model state
  logic [1:0]  req_st = STATUS_IDLE;
  logic [16:0] ms_count = '0;
  logic [15:0] ms_limit = '0;
  int          ok_pos = 0;
  int          err_pos = 0;
  bit          modem_pwr = 1'b0;

  reply_t      pending_replies[$];
  beat_t       queued_beats[$];

  int errors = 0;
  int n_items = 0;
  int n_opened = 0;
  int n_refused = 0;
  int n_ok = 0;
  int n_err = 0;
  int n_timeouts = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet = 0;
  int hold_left = 0;
  bit hold_trig = 1'b0;
  bit hold_seen = 1'b0;

  at_response_waiter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .in_timeout_ms   (in_timeout_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_accepted    (out_accepted),
    .out_byte_kept   (out_byte_kept),
    .out_kept_byte   (out_kept_byte),
    .out_found_ok    (out_found_ok),
    .out_found_error (out_found_error),
    .out_finished    (out_finished)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_bad(string what, int got_v, int want_v);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("[%0t] bad %s: got %0h, expected %0h", $time, what, got_v, want_v);
    end
  endtask

  // streaming terminator matcher, falls back to one on a stray CR
  function automatic bit match_adv(inout int pos, input int len, input logic [7:0] want_c,
                                   input logic [7:0] c);
    if (c == want_c) begin
      pos++;
      if (pos == len) begin
        pos = 0;
        return 1'b1;
      end
      return 1'b0;
    end
    pos = (c == CHAR_CR) ? 1 : 0;
    return 1'b0;
  endfunction

  function automatic reply_t advance_waiter(beat_t b);
    reply_t r;
    bit     take;
    r = '0;
    take = 1'b0;
    case (b.op)
      OP_START: begin
        if (modem_pwr && req_st == STATUS_IDLE) begin
          ms_limit = b.tmo;
          ms_count = '0;
          ok_pos = 0;
          err_pos = 0;
          req_st = STATUS_SENT;
          r.accepted = 1'b1;
          n_opened++;
        end else begin
          n_refused++;
        end
      end
      OP_BYTE: begin
        if (req_st == STATUS_SENT) begin
          req_st = STATUS_STARTED;
          take = 1'b1;
        end else if (req_st == STATUS_STARTED) begin
          if (ms_count > ms_limit) begin
            req_st = STATUS_TIMEOUT;
            n_timeouts++;
          end else begin
            take = 1'b1;
          end
        end
        if (take) begin
          r.byte_kept = 1'b1;
          r.kept_byte = b.data;
          r.found_ok = match_adv(ok_pos, OK_LEN, OK_PATTERN[8*(OK_LEN-1-ok_pos) +: 8], b.data);
          r.found_error = match_adv(err_pos, ERR_LEN, ERR_PATTERN[8*(ERR_LEN-1-err_pos) +: 8],
                                    b.data);
          if (r.found_ok) n_ok++;
          if (r.found_error) n_err++;
          if (r.found_ok || r.found_error) req_st = STATUS_IDLE;
        end
      end
      OP_TICK: begin
        if (ms_count < MS_MAX) ms_count = ms_count + 1'b1;
        if ((req_st == STATUS_SENT || req_st == STATUS_STARTED) && ms_count > ms_limit) begin
          req_st = STATUS_TIMEOUT;
          n_timeouts++;
        end
      end
      default: begin
        if (req_st == STATUS_IDLE || req_st == STATUS_TIMEOUT) begin
          r.finished = 1'b1;
          req_st = STATUS_IDLE;
        end
      end
    endcase
    r.status = req_st;
    return r;
  endfunction

  function automatic beat_t mk_beat(op_t op, logic [7:0] d, logic [15:0] t);
    beat_t b;
    b.op = op;
    b.data = d;
    b.tmo = t;
    return b;
  endfunction

  function automatic dir_row_t step_row(op_t op, logic [7:0] d, logic [15:0] t);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_val = 1'b0;
    row.beat = mk_beat(op, d, t);
    row.known = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t known_row(op_t op, logic [7:0] d, logic [15:0] t, reply_t w);
    dir_row_t row;
    row = step_row(op, d, t);
    row.known = 1'b1;
    row.want = w;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(bit v);
    dir_row_t row;
    row = step_row(OP_TICK, 8'h00, 16'h0000);
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  // one beat; the model advances at the edge where it is taken
  task automatic send_beat(beat_t b, bit known, reply_t w);
    reply_t r;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid      <= 1'b1;
    in_opcode     <= b.op;
    in_data_byte  <= b.data;
    in_timeout_ms <= b.tmo;
    do @(posedge clk); while (!in_ready);
    r = advance_waiter(b);
    pending_replies.push_back(known ? w : r);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  task automatic cfg_write(bit v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    modem_pwr = v;
  endtask

  function automatic logic [7:0] reply_char();
    case ($urandom_range(0, 7))
      0: return CHAR_CR;
      1: return 8'h0a;
      2: return "O";
      3: return "K";
      4: return "E";
      5: return "R";
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 8));
    endcase
  endfunction

  // one request: start, reply with ticks, terminator (at times cut or none), collects
  task automatic queue_request();
    int n;
    int kind;
    int len;
    logic [7:0] c;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 5)) begin
        queued_beats.push_back(mk_beat(op_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom)));
      end
    end
    queued_beats.push_back(mk_beat(OP_START, 8'($urandom), pick_timeout()));
    n = $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(0, 99) < 30) begin
        queued_beats.push_back(mk_beat(OP_TICK, 8'($urandom), 16'($urandom)));
      end else begin
        queued_beats.push_back(mk_beat(OP_BYTE, reply_char(), 16'($urandom)));
      end
    end
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      len = (kind < 4 || kind == 7) ? OK_LEN : ERR_LEN;
      if (kind >= 7) len = $urandom_range(1, len - 1);
      for (int i = 0; i < len; i++) begin
        if (kind < 4 || kind == 7) c = OK_PATTERN[8*(OK_LEN-1-i) +: 8];
        else c = ERR_PATTERN[8*(ERR_LEN-1-i) +: 8];
        queued_beats.push_back(mk_beat(OP_BYTE, c, 16'($urandom)));
      end
    end
    if ($urandom_range(0, 9) < 8) begin
      repeat ($urandom_range(1, 2)) begin
        queued_beats.push_back(mk_beat(OP_COLLECT, 8'($urandom), 16'($urandom)));
      end
    end
  endtask

  task automatic run_random(int count, bit with_hold);
    int first;
    bit held;
    first = n_items;
    held = 1'b0;
    while (n_items - first < count) begin
      if (with_hold && !held && n_items - first >= 40) begin
        hold_trig <= ~hold_trig;
        held = 1'b1;
      end
      queue_request();
      while (queued_beats.size() != 0) send_beat(queued_beats.pop_front(), 1'b0, '0);
    end
    drain();
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  reply_t got;
  reply_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = {out_status, out_accepted, out_byte_kept, out_kept_byte,
             out_found_ok, out_found_error, out_finished};
      if (pending_replies.size() == 0) begin
        note_bad("unexpected result beat, status", got.status, 0);
      end else begin
        want = pending_replies.pop_front();
        if (got.status != want.status) note_bad("status", got.status, want.status);
        if (got.accepted != want.accepted) note_bad("accepted", got.accepted, want.accepted);
        if (got.byte_kept != want.byte_kept) note_bad("byte_kept", got.byte_kept, want.byte_kept);
        if (got.kept_byte != want.kept_byte) note_bad("kept_byte", got.kept_byte, want.kept_byte);
        if (got.found_ok != want.found_ok) note_bad("found_ok", got.found_ok, want.found_ok);
        if (got.found_error != want.found_error) begin
          note_bad("found_error", got.found_error, want.found_error);
        end
        if (got.finished != want.finished) note_bad("finished", got.finished, want.finished);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("at_response_waiter: mismatch");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset the modem is off and the tracker idle
    dir_rows.push_back(known_row(OP_COLLECT, 8'h00, 16'h0000,
                                 {STATUS_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}));
    dir_rows.push_back(known_row(OP_START, 8'hff, 16'h0005,
                                 {STATUS_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(known_row(OP_BYTE, 8'hff, 16'hffff,
                                 {STATUS_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(cfg_row(1'b1));
    dir_rows.push_back(known_row(OP_START, 8'h00, 16'hffff,
                                 {STATUS_SENT, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}));
    // busy: second start refused, collect not finished
    dir_rows.push_back(known_row(OP_START, 8'h00, 16'h0000,
                                 {STATUS_SENT, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(known_row(OP_COLLECT, 8'h00, 16'h0000,
                                 {STATUS_SENT, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(known_row(OP_BYTE, CHAR_CR, 16'h0000,
                                 {STATUS_STARTED, 1'b0, 1'b1, CHAR_CR, 1'b0, 1'b0, 1'b0}));
    // stray second CR falls back to position one
    dir_rows.push_back(step_row(OP_BYTE, CHAR_CR, 16'h0000));
    dir_rows.push_back(step_row(OP_BYTE, 8'h0a, 16'h0000));
    dir_rows.push_back(step_row(OP_BYTE, "O", 16'h0000));
    dir_rows.push_back(step_row(OP_BYTE, "K", 16'h0000));
    dir_rows.push_back(step_row(OP_BYTE, CHAR_CR, 16'h0000));
    dir_rows.push_back(step_row(OP_BYTE, 8'h0a, 16'h0000));
    dir_rows.push_back(step_row(OP_COLLECT, 8'h00, 16'h0000));
    // zero timeout: first tick times out, later bytes dropped
    dir_rows.push_back(known_row(OP_START, 8'h00, 16'h0000,
                                 {STATUS_SENT, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(known_row(OP_TICK, 8'h00, 16'h0000,
                                 {STATUS_TIMEOUT, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(known_row(OP_BYTE, 8'h00, 16'h0000,
                                 {STATUS_TIMEOUT, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(known_row(OP_COLLECT, 8'h00, 16'h0000,
                                 {STATUS_IDLE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}));
    dir_rows.push_back(step_row(OP_START, 8'h00, 16'h0003));
    for (int i = 0; i < ERR_LEN; i++) begin
      dir_rows.push_back(step_row(OP_BYTE, ERR_PATTERN[8*(ERR_LEN-1-i) +: 8], 16'h0000));
    end

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        cfg_write(dir_rows[i].cfg_val);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].want);
      end
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      cfg_write(1'b1);
      run_random(PHASE_ITEMS, ph == 0);
      cfg_write(1'b0);
      run_random(OFF_ITEMS, 1'b0);
    end

    drain();
    $display("covered %0d beats over four idling mixes, modem on and off", n_items);
    $display("requests opened %0d, refused %0d; ok %0d, error %0d, timeouts %0d",
             n_opened, n_refused, n_ok, n_err, n_timeouts);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("at_response_waiter: match");
    end else begin
      $display("at_response_waiter: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/at_rw_pkg.sv
hdl/at_rw_matcher.sv
hdl/at_rw_core.sv
hdl/at_response_waiter.sv
tb/tb_at_response_waiter.sv
